// ----- hdl/dbd_pkg.sv -----
// Shared widths, calendar tables and helper functions for the day-distance block.
// Used by dbd_date and by the top level days_between_dates. No dependencies.
`default_nettype none
package dbd_pkg;

  localparam int YEAR_W     = 12;
  localparam int MONTH_W    = 4;
  localparam int DAY_W      = 5;
  localparam int WDAY_W     = 3;
  localparam int SERIAL_W   = 21;
  localparam int MAX_YEAR_D = 4095;
  localparam int NUM_STG    = 5;

  localparam int DIV100_MUL = 5243;
  localparam int DIV100_SH  = 19;
  localparam int QUOT_W     = 6;

  localparam logic [WDAY_W-1:0]  WDAY_UNKNOWN = 3'd7;
  localparam logic [MONTH_W-1:0] MONTH_FEB    = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC    = 4'd12;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } dbd_en_t;

  function automatic logic [QUOT_W-1:0] div100(input logic [YEAR_W-1:0] v);
    logic [YEAR_W+13-1:0] prod;
    prod = (YEAR_W+13)'(v) * (YEAR_W+13)'(DIV100_MUL);
    return prod[DIV100_SH +: QUOT_W];
  endfunction

  function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
    logic [8:0] r;
    unique case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] r;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   r = 5'd30;
      4'd2:                                      r = leap ? 5'd29 : 5'd28;
      default:                                   r = 5'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/dbd_date.sv -----
// Five-stage converter from one date (day form or Nth-weekday form) to a serial day.
// Depends on dbd_pkg; stage enables come from the top level's valid chain.
`default_nettype none
module dbd_date
  import dbd_pkg::*;
#(
  parameter int MAX_YEAR = MAX_YEAR_D
) (
  input  wire logic                clk,
  input  wire dbd_en_t             en,
  input  wire logic                nth,
  input  wire logic [YEAR_W-1:0]   year,
  input  wire logic [MONTH_W-1:0]  month,
  input  wire logic [DAY_W-1:0]    dcount,
  input  wire logic [WDAY_W-1:0]   weekday,
  output logic [SERIAL_W-1:0]      serial,
  output logic                     ok
);

  // Stage 1: range checks and the reciprocal divisions by 100.
  logic                nth1_r, ok1_r;
  logic [YEAR_W-1:0]   y1_r, p1_r;
  logic [QUOT_W-1:0]   qy1_r, qp1_r;
  logic [MONTH_W-1:0]  m1_r;
  logic [DAY_W-1:0]    d1_r;
  logic [WDAY_W-1:0]   w1_r;
  logic                ok1_nxt;
  logic [YEAR_W-1:0]   p1_nxt;

  always_comb begin
    p1_nxt  = year - YEAR_W'(1);
    ok1_nxt = (year != '0) && (year <= YEAR_W'(MAX_YEAR)) &&
              (month != '0) && (month <= MONTH_DEC);
    if (nth) begin
      ok1_nxt = ok1_nxt && (weekday != WDAY_UNKNOWN) && (dcount != '0) &&
                (dcount <= DAY_W'(5));
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      nth1_r <= nth;
      ok1_r  <= ok1_nxt;
      y1_r   <= year;
      p1_r   <= p1_nxt;
      qy1_r  <= div100(year);
      qp1_r  <= div100(p1_nxt);
      m1_r   <= month;
      d1_r   <= dcount;
      w1_r   <= weekday;
    end
  end

  // Stage 2: leap year, month length and the day count of all earlier years.
  logic                nth2_r, ok2_r, leap2_r;
  logic [SERIAL_W-1:0] base2_r;
  logic [MONTH_W-1:0]  m2_r;
  logic [DAY_W-1:0]    d2_r, len2_r;
  logic [WDAY_W-1:0]   w2_r;
  logic                cent2, leap2_nxt;
  logic [YEAR_W-1:0]   rem2;
  logic [SERIAL_W-1:0] base2_nxt;

  always_comb begin
    rem2      = y1_r - YEAR_W'(qy1_r) * YEAR_W'(100);
    cent2     = (rem2 == '0);
    leap2_nxt = ((y1_r[1:0] == 2'b00) && !cent2) || (cent2 && (qy1_r[1:0] == 2'b00));
    base2_nxt = SERIAL_W'(p1_r) * SERIAL_W'(365) + SERIAL_W'(p1_r[YEAR_W-1:2])
              - SERIAL_W'(qp1_r) + SERIAL_W'(qp1_r[QUOT_W-1:2]);
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      nth2_r  <= nth1_r;
      ok2_r   <= ok1_r;
      leap2_r <= leap2_nxt;
      base2_r <= base2_nxt;
      m2_r    <= m1_r;
      d2_r    <= d1_r;
      len2_r  <= month_len(m1_r, leap2_nxt);
      w2_r    <= w1_r;
    end
  end

  // Stage 3: serial day of the first of the month.
  logic                nth3_r, ok3_r;
  logic [SERIAL_W-1:0] first3_r;
  logic [DAY_W-1:0]    d3_r, len3_r;
  logic [WDAY_W-1:0]   w3_r;
  logic [SERIAL_W-1:0] first3_nxt;

  always_comb begin
    first3_nxt = base2_r + SERIAL_W'(days_before(m2_r)) + SERIAL_W'(1);
    if ((m2_r > MONTH_FEB) && leap2_r) begin
      first3_nxt = first3_nxt + SERIAL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      nth3_r   <= nth2_r;
      ok3_r    <= ok2_r;
      first3_r <= first3_nxt;
      d3_r     <= d2_r;
      len3_r   <= len2_r;
      w3_r     <= w2_r;
    end
  end

  // Stage 4: weekday of the first of the month, as the serial day modulo 7.
  logic                nth4_r, ok4_r;
  logic [SERIAL_W-1:0] first4_r;
  logic [DAY_W-1:0]    d4_r, len4_r;
  logic [WDAY_W-1:0]   w4_r, wd4_r;
  logic [5:0]          sum4;
  logic [3:0]          fold4;
  logic [WDAY_W-1:0]   wd4_nxt;

  always_comb begin
    sum4 = '0;
    for (int i = 0; i < SERIAL_W / 3; i++) begin
      sum4 = sum4 + 6'(first3_r[3*i +: 3]);
    end
    fold4 = 4'(sum4[5:3]) + 4'(sum4[2:0]);
    if (fold4 >= 4'd7) begin
      fold4 = fold4 - 4'd7;
    end
    if (fold4 >= 4'd7) begin
      fold4 = fold4 - 4'd7;
    end
    wd4_nxt = fold4[WDAY_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en.s4) begin
      nth4_r   <= nth3_r;
      ok4_r    <= ok3_r;
      first4_r <= first3_r;
      d4_r     <= d3_r;
      len4_r   <= len3_r;
      w4_r     <= w3_r;
      wd4_r    <= wd4_nxt;
    end
  end

  // Stage 5: day of the month, bounds check and the final serial day.
  logic                ok5_r;
  logic [SERIAL_W-1:0] serial5_r;
  logic [3:0]          off5;
  logic [7:0]          day5;

  always_comb begin
    off5 = 4'(w4_r) + 4'd7 - 4'(wd4_r);
    if (off5 >= 4'd7) begin
      off5 = off5 - 4'd7;
    end
    if (nth4_r) begin
      day5 = 8'd1 + 8'(off5) + 8'(8'(d4_r - DAY_W'(1)) * 8'd7);
    end else begin
      day5 = 8'(d4_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en.s5) begin
      ok5_r     <= ok4_r && (day5 != '0) && (day5 <= 8'(len4_r));
      serial5_r <= first4_r + SERIAL_W'(day5) - SERIAL_W'(1);
    end
  end

  assign serial = serial5_r;
  assign ok     = ok5_r;

endmodule
`default_nettype wire

// ----- hdl/days_between_dates.sv -----
// Days between two Gregorian dates: two dbd_date converters and an output register.
// Throughput one pair of dates per cycle while results are taken; each pipeline
// stage stalls only when full and its successor cannot take data, so bubbles are
// squeezed out. Reset clears all valid bits; payload and result are not reset.
// Depends on dbd_pkg and dbd_date.
`default_nettype none
module days_between_dates
  import dbd_pkg::*;
#(
  parameter int MAX_YEAR = MAX_YEAR_D
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [1:0]           in_opcode,
  input  wire logic [YEAR_W-1:0]    in_first_year,
  input  wire logic [MONTH_W-1:0]   in_first_month,
  input  wire logic [DAY_W-1:0]     in_first_day_or_count,
  input  wire logic [WDAY_W-1:0]    in_first_weekday,
  input  wire logic [YEAR_W-1:0]    in_second_year,
  input  wire logic [MONTH_W-1:0]   in_second_month,
  input  wire logic [DAY_W-1:0]     in_second_day_or_count,
  input  wire logic [WDAY_W-1:0]    in_second_weekday,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_invalid_date,
  output logic [SERIAL_W-1:0]       out_day_distance
);

  logic [NUM_STG-1:0]  vld_r;
  logic [NUM_STG-1:0]  stg_en;
  logic                out_en;
  logic                out_valid_r, out_invalid_r;
  logic [SERIAL_W-1:0] out_dist_r;
  dbd_en_t             en;
  logic [SERIAL_W-1:0] serial_a, serial_b;
  logic                ok_a, ok_b;

  always_comb begin
    out_en              = !out_valid_r || out_ready;
    stg_en[NUM_STG-1]   = !vld_r[NUM_STG-1] || out_en;
    for (int k = NUM_STG - 2; k >= 0; k--) begin
      stg_en[k] = !vld_r[k] || stg_en[k+1];
    end
  end

  assign en       = '{s1: stg_en[0], s2: stg_en[1], s3: stg_en[2], s4: stg_en[3],
                      s5: stg_en[4]};
  assign in_ready = stg_en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (stg_en[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < NUM_STG; k++) begin
        if (stg_en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
      if (out_en) begin
        out_valid_r <= vld_r[NUM_STG-1];
      end
    end
  end

  dbd_date #(.MAX_YEAR(MAX_YEAR)) u_date_a (
    .clk     (clk),
    .en      (en),
    .nth     (in_opcode[1]),
    .year    (in_first_year),
    .month   (in_first_month),
    .dcount  (in_first_day_or_count),
    .weekday (in_first_weekday),
    .serial  (serial_a),
    .ok      (ok_a)
  );

  dbd_date #(.MAX_YEAR(MAX_YEAR)) u_date_b (
    .clk     (clk),
    .en      (en),
    .nth     (in_opcode[0]),
    .year    (in_second_year),
    .month   (in_second_month),
    .dcount  (in_second_day_or_count),
    .weekday (in_second_weekday),
    .serial  (serial_b),
    .ok      (ok_b)
  );

  always_ff @(posedge clk) begin
    if (out_en) begin
      out_invalid_r <= !(ok_a && ok_b);
      if (!(ok_a && ok_b)) begin
        out_dist_r <= '0;
      end else if (serial_a >= serial_b) begin
        out_dist_r <= serial_a - serial_b;
      end else begin
        out_dist_r <= serial_b - serial_a;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_invalid_date = out_invalid_r;
  assign out_day_distance = out_dist_r;

endmodule
`default_nettype wire

// ----- hdl/dbd_checker.sv -----
// Port-level checks for days_between_dates, attached by the bind statement below.
// Depends on dbd_pkg for field widths.
`default_nettype none
module dbd_checker
  import dbd_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic                out_invalid_date,
  input wire logic [SERIAL_W-1:0] out_day_distance
);

  // A stalled result transfer keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_invalid_date) &&
                                $stable(out_day_distance))
    else $error("result changed while stalled");

  // An invalid date always reports a distance of zero.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_invalid_date |-> out_day_distance == '0)
    else $error("nonzero distance on invalid date");

  // The input side backs up only when the output holds a result that is not taken.
  a_ready_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

endmodule

bind days_between_dates dbd_checker u_dbd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_invalid_date (out_invalid_date),
  .out_day_distance (out_day_distance)
);
`default_nettype wire

// ----- verif/tb.sv -----
// Self-checking testbench for days_between_dates: directed and random date pairs,
// predicted in a scoreboard class and compared with every result transfer.
// Depends on dbd_pkg and the days_between_dates RTL.
`timescale 1ns / 1ps
module tb;
  import dbd_pkg::*;

  localparam int N_RANDOM   = 1330;
  localparam int QUIET_TAIL = 150;
  localparam int LONG_HOLD  = 90;
  localparam int DRAIN_MAX  = 5000;

  typedef enum logic [1:0] {
    OP_DAY_DAY = 2'd0,
    OP_DAY_NTH = 2'd1,
    OP_NTH_DAY = 2'd2,
    OP_NTH_NTH = 2'd3
  } date_form_t;

  typedef enum logic [WDAY_W-1:0] {
    WD_SUN, WD_MON, WD_TUE, WD_WED, WD_THU, WD_FRI, WD_SAT
  } weekday_t;

  typedef struct packed {
    date_form_t           op;
    logic [YEAR_W-1:0]    first_year;
    logic [MONTH_W-1:0]   first_month;
    logic [DAY_W-1:0]     first_day;
    logic [WDAY_W-1:0]    first_wday;
    logic [YEAR_W-1:0]    second_year;
    logic [MONTH_W-1:0]   second_month;
    logic [DAY_W-1:0]     second_day;
    logic [WDAY_W-1:0]    second_wday;
  } date_pair_t;

  typedef struct {
    bit                   invalid;
    logic [SERIAL_W-1:0]  distance;
  } day_gap_t;

  class day_gap_board;
    day_gap_t gap_q[$];
    int       mismatches;

    function new();
      mismatches = 0;
    endfunction

    static function bit leap_year(int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    static function int unsigned days_in_month(int unsigned y, int unsigned m);
      case (m)
        2: begin
          return leap_year(y) ? 29 : 28;
        end
        4, 6, 9, 11: begin
          return 30;
        end
        default: begin
          return 31;
        end
      endcase
    endfunction

    function int unsigned month_origin(int unsigned y, int unsigned m);
      int unsigned p;
      int unsigned s;
      p = y - 1;
      s = 365 * p + p / 4 - p / 100 + p / 400;
      for (int unsigned k = 1; k < m; k++) begin
        s += days_in_month(y, k);
      end
      return s + 1;
    endfunction

    function bit date_serial(bit nth, int unsigned y, int unsigned m, int unsigned d,
                             int unsigned w, output int unsigned serial);
      int unsigned origin;
      int unsigned day;
      serial = 0;
      if (y < 1 || y > MAX_YEAR_D || m < 1 || m > 12) begin
        return 0;
      end
      origin = month_origin(y, m);
      if (nth) begin
        if (w == WDAY_UNKNOWN || d < 1 || d > 5) begin
          return 0;
        end
        day = 1 + (w + 7 - origin % 7) % 7 + 7 * (d - 1);
      end else begin
        day = d;
      end
      if (day < 1 || day > days_in_month(y, m)) begin
        return 0;
      end
      serial = origin + day - 1;
      return 1;
    endfunction

    function void note_request(date_pair_t p);
      int unsigned s1;
      int unsigned s2;
      bit          ok1;
      bit          ok2;
      day_gap_t    g;
      ok1 = date_serial(p.op inside {OP_NTH_DAY, OP_NTH_NTH}, p.first_year,
                        p.first_month, p.first_day, p.first_wday, s1);
      ok2 = date_serial(p.op inside {OP_DAY_NTH, OP_NTH_NTH}, p.second_year,
                        p.second_month, p.second_day, p.second_wday, s2);
      g.invalid  = !(ok1 && ok2);
      g.distance = g.invalid ? '0 : SERIAL_W'((s1 >= s2) ? s1 - s2 : s2 - s1);
      gap_q = {gap_q, g};
    endfunction

    function void check_result(bit invalid, logic [SERIAL_W-1:0] distance);
      day_gap_t g;
      if (gap_q.size() == 0) begin
        if (mismatches < 10) begin
          $display("Unexpected result: invalid=%0b distance=%0d", invalid, distance);
        end
        mismatches++;
        return;
      end
      g = gap_q.pop_front();
      if (g.invalid !== invalid || g.distance !== distance) begin
        if (mismatches < 10) begin
          $display("Mismatch: expected invalid=%0b distance=%0d, got invalid=%0b distance=%0d",
                   g.invalid, g.distance, invalid, distance);
        end
        mismatches++;
      end
    endfunction

    function int pending();
      return gap_q.size();
    endfunction

    function void flag_leftovers();
      if (gap_q.size() != 0) begin
        $display("%0d expected results never arrived", gap_q.size());
        mismatches += gap_q.size();
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [1:0]           in_opcode;
  logic [YEAR_W-1:0]    in_first_year;
  logic [MONTH_W-1:0]   in_first_month;
  logic [DAY_W-1:0]     in_first_day_or_count;
  logic [WDAY_W-1:0]    in_first_weekday;
  logic [YEAR_W-1:0]    in_second_year;
  logic [MONTH_W-1:0]   in_second_month;
  logic [DAY_W-1:0]     in_second_day_or_count;
  logic [WDAY_W-1:0]    in_second_weekday;
  logic                 out_valid;
  logic                 out_ready;
  logic                 out_invalid_date;
  logic [SERIAL_W-1:0]  out_day_distance;

  day_gap_board board;

  days_between_dates u_top (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_opcode              (in_opcode),
    .in_first_year          (in_first_year),
    .in_first_month         (in_first_month),
    .in_first_day_or_count  (in_first_day_or_count),
    .in_first_weekday       (in_first_weekday),
    .in_second_year         (in_second_year),
    .in_second_month        (in_second_month),
    .in_second_day_or_count (in_second_day_or_count),
    .in_second_weekday      (in_second_weekday),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_invalid_date       (out_invalid_date),
    .out_day_distance       (out_day_distance)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(5_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      board.check_result(out_invalid_date, out_day_distance);
    end
  end

  function automatic date_pair_t pair_of(date_form_t op, int y1, int m1, int d1, int w1,
                                         int y2, int m2, int d2, int w2);
    date_pair_t p;
    p.op           = op;
    p.first_year   = YEAR_W'(y1);
    p.first_month  = MONTH_W'(m1);
    p.first_day    = DAY_W'(d1);
    p.first_wday   = WDAY_W'(w1);
    p.second_year  = YEAR_W'(y2);
    p.second_month = MONTH_W'(m2);
    p.second_day   = DAY_W'(d2);
    p.second_wday  = WDAY_W'(w2);
    return p;
  endfunction

  task automatic random_date(input bit nth, output logic [YEAR_W-1:0] y,
                             output logic [MONTH_W-1:0] m, output logic [DAY_W-1:0] d,
                             output logic [WDAY_W-1:0] w);
    int unsigned len;
    case ($urandom_range(0, 15))
      0:       y = YEAR_W'(1);
      1:       y = YEAR_W'(MAX_YEAR_D);
      2:       y = YEAR_W'(400 * $urandom_range(1, 10));
      3:       y = YEAR_W'(100 * $urandom_range(1, 40));
      default: y = YEAR_W'($urandom_range(1, MAX_YEAR_D));
    endcase
    m = MONTH_W'($urandom_range(1, 12));
    if (nth) begin
      d = DAY_W'($urandom_range(1, 5));
      w = ($urandom_range(0, 15) == 0) ? WDAY_UNKNOWN : WDAY_W'($urandom_range(0, 6));
    end else begin
      len = day_gap_board::days_in_month(y, m);
      d = ($urandom_range(0, 19) == 0) ? DAY_W'(len + 1) : DAY_W'($urandom_range(1, len));
      w = WDAY_W'($urandom);
    end
  endtask

  task automatic random_pair(output date_pair_t p);
    if ($urandom_range(0, 4) == 0) begin
      p = date_pair_t'({$urandom, $urandom});
    end else begin
      p.op = date_form_t'($urandom_range(0, 3));
      random_date(p.op inside {OP_NTH_DAY, OP_NTH_NTH},
                  p.first_year, p.first_month, p.first_day, p.first_wday);
      random_date(p.op inside {OP_DAY_NTH, OP_NTH_NTH},
                  p.second_year, p.second_month, p.second_day, p.second_wday);
    end
  endtask

  task automatic send_pair(input date_pair_t p);
    in_valid               <= 1'b1;
    in_opcode              <= p.op;
    in_first_year          <= p.first_year;
    in_first_month         <= p.first_month;
    in_first_day_or_count  <= p.first_day;
    in_first_weekday       <= p.first_wday;
    in_second_year         <= p.second_year;
    in_second_month        <= p.second_month;
    in_second_day_or_count <= p.second_day;
    in_second_weekday      <= p.second_wday;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_request(p);
  endtask

  // The receiver counts its own transfers so that its long hold-off and its quiet
  // tail do not depend on the order in which the processes woken by the clock run.
  initial begin
    int got;
    int burst_left;
    bit held;
    got        = 0;
    burst_left = 0;
    held       = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        got++;
      end
      if (!held && got >= 200) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (burst_left > 0) begin
        burst_left--;
        out_ready <= 1'b0;
      end else if (got < N_RANDOM - 130 && (got / 100) % 3 != 2 &&
                   $urandom_range(0, 7) == 0) begin
        burst_left = $urandom_range(1, 14) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    date_pair_t plan_q[$];
    date_pair_t p;
    int         waited;
    board = new();
    in_valid               <= 1'b0;
    in_opcode              <= OP_DAY_DAY;
    in_first_year          <= '0;
    in_first_month         <= '0;
    in_first_day_or_count  <= '0;
    in_first_weekday       <= '0;
    in_second_year         <= '0;
    in_second_month        <= '0;
    in_second_day_or_count <= '0;
    in_second_weekday      <= '0;
    rst_n                  <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    plan_q = {plan_q, pair_of(OP_DAY_DAY, 1, 1, 1, WD_SUN, 1, 1, 1, WD_SUN)};
    plan_q = {plan_q, pair_of(OP_DAY_DAY, 1, 1, 1, WD_SUN, MAX_YEAR_D, 12, 31, WD_SUN)};
    plan_q = {plan_q, pair_of(OP_DAY_DAY, MAX_YEAR_D, 12, 31, WD_SAT, 1, 1, 1, WD_MON)};
    plan_q = {plan_q, pair_of(OP_DAY_DAY, 0, 1, 1, WD_SUN, 2000, 1, 1, WD_SUN)};
    plan_q = {plan_q, pair_of(OP_DAY_DAY, 2000, 0, 1, WD_SUN, 2000, 1, 1, WD_SUN)};
    plan_q = {plan_q, pair_of(OP_DAY_DAY, 2000, 1, 1, WD_SUN, 2000, 13, 1, WD_SUN)};
    plan_q = {plan_q, pair_of(OP_DAY_DAY, 2000, 1, 0, WD_SUN, 2000, 15, 31, WD_SUN)};
    plan_q = {plan_q, pair_of(OP_DAY_DAY, 2000, 2, 29, WD_SUN, 2024, 2, 29, WD_SUN)};
    plan_q = {plan_q, pair_of(OP_DAY_DAY, 1900, 2, 29, WD_SUN, 1900, 3, 1, WD_SUN)};
    plan_q = {plan_q, pair_of(OP_DAY_DAY, 2023, 2, 29, WD_SUN, 2023, 2, 28, WD_SUN)};
    plan_q = {plan_q, pair_of(OP_DAY_DAY, 2023, 4, 31, WD_SUN, 2023, 4, 30, WD_SUN)};
    // In day form the weekday field carries no meaning, even the unknown code.
    plan_q = {plan_q, pair_of(OP_DAY_DAY, 1, 1, 1, WDAY_UNKNOWN, 400, 12, 31, WDAY_UNKNOWN)};
    plan_q = {plan_q, pair_of(OP_NTH_NTH, 1, 1, 1, WD_MON, 1, 1, 1, WD_SUN)};
    plan_q = {plan_q, pair_of(OP_NTH_NTH, 2024, 2, 5, WD_THU, 2023, 2, 4, WD_TUE)};
    plan_q = {plan_q, pair_of(OP_NTH_NTH, 2024, 2, 5, WD_FRI, 2024, 3, 5, WD_SUN)};
    plan_q = {plan_q, pair_of(OP_NTH_NTH, 2024, 5, 0, WD_SUN, 2024, 5, 1, WD_SUN)};
    plan_q = {plan_q, pair_of(OP_NTH_NTH, 2024, 5, 6, WD_SUN, 2024, 5, 2, WD_SAT)};
    plan_q = {plan_q, pair_of(OP_NTH_NTH, 2024, 5, 1, WDAY_UNKNOWN, 2024, 5, 1, WD_WED)};
    plan_q = {plan_q, pair_of(OP_NTH_DAY, MAX_YEAR_D, 12, 5, WD_SAT, 1, 1, 1, WD_SUN)};
    plan_q = {plan_q, pair_of(OP_DAY_NTH, 1, 1, 31, WD_SUN, MAX_YEAR_D, 12, 5, WD_TUE)};
    plan_q = {plan_q, pair_of(OP_DAY_NTH, 1999, 12, 31, WD_SUN, 2000, 1, 1, WD_SAT)};
    plan_q = {plan_q, pair_of(OP_NTH_NTH, MAX_YEAR_D, 15, 31, WDAY_UNKNOWN,
                              MAX_YEAR_D, 15, 31, WDAY_UNKNOWN)};
    foreach (plan_q[i]) begin
      send_pair(plan_q[i]);
    end

    for (int i = 0; i < N_RANDOM; i++) begin
      random_pair(p);
      send_pair(p);
      if (i == N_RANDOM / 2) begin
        in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
      end else if (i < N_RANDOM - QUIET_TAIL && (i / 120) % 4 != 3 &&
                   $urandom_range(0, 5) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
    end
    in_valid <= 1'b0;

    waited = 0;
    while (board.pending() != 0 && waited < DRAIN_MAX) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    board.flag_leftovers();
    if (board.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
